[rtl/core/grid_stencil_step_fixed_border_macros.svh]
// ----------------------------------------------------------------------------
// grid_stencil_step_fixed_border assertion macros
// Concurrent assertion shorthands on aclk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef GRID_STENCIL_STEP_FIXED_BORDER_MACROS_SVH
`define GRID_STENCIL_STEP_FIXED_BORDER_MACROS_SVH

// checked only while out of reset
`define GSFB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define GSFB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/gsfb_pkg.sv]
// ----------------------------------------------------------------------------
// gsfb_pkg
// Shared types and constants of the 3x3 stencil step with fixed border.
// ----------------------------------------------------------------------------
`default_nettype none

package gsfb_pkg;

    localparam int VAL_W       = 16;
    localparam int CELL_W      = 10;
    localparam int SIZE_W      = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_RES     = 4;
    localparam int NRES_W      = 3;
    localparam int SUM_W       = 20;
    localparam int PROD_W      = 37;
    localparam int FIFO_DEPTH  = 16;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int NEED_W      = CNT_W + 1;

    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_COLS_DEF = 1024;

    localparam logic signed [VAL_W-1:0] TOP_EDGE_RST   = 16'sd768;
    localparam logic signed [VAL_W-1:0] BOT_EDGE_RST   = 16'sd1792;
    localparam logic signed [VAL_W-1:0] LEFT_EDGE_RST  = 16'sd512;
    localparam logic signed [VAL_W-1:0] RIGHT_EDGE_RST = 16'sd2048;
    localparam logic [VAL_W-1:0]        GAIN_RST       = 16'd6554;
    localparam logic [SIZE_W-1:0]       ROWS_RST       = 11'd10;
    localparam logic [SIZE_W-1:0]       COLS_RST       = 11'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_EDGE   = 3'd0,
        CFG_BOT_EDGE   = 3'd1,
        CFG_LEFT_EDGE  = 3'd2,
        CFG_RIGHT_EDGE = 3'd3,
        CFG_GAIN       = 3'd4,
        CFG_ROWS       = 3'd5,
        CFG_COLS       = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] top_edge;
        logic signed [VAL_W-1:0] bot_edge;
        logic signed [VAL_W-1:0] left_edge;
        logic signed [VAL_W-1:0] right_edge;
        logic [VAL_W-1:0]        gain;
    } edge_cfg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_value;
        logic [CELL_W-1:0]       cell_row;
        logic [CELL_W-1:0]       cell_col;
        logic                    last_in_step;
        logic                    last_of_grid;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/grid_stencil_step_fixed_border.sv]
// A taken item passes the window and calc registers; its results then enter the result queue for the m_ side.
// Throughput: one item per cycle while s_ready is high; each item gives 0, 1, 2 or 4 results and the
// m_ side moves one result per cycle while m_ready is high, through a 16-entry result queue.
// s_ready drops when the queue cannot hold 4 more results beyond those in flight.
// Reset (aresetn low, synchronous): counters, window, queue and registers to
// defaults; line stores are not cleared.
// ----------------------------------------------------------------------------
// grid_stencil_step_fixed_border
// One 3x3 box stencil step with fixed per-edge border over a raster-order grid.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_stencil_step_fixed_border #(
    parameter int MAX_ROWS = gsfb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gsfb_pkg::MAX_COLS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gsfb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsfb_pkg::VAL_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gsfb_pkg::VAL_W-1:0]   s_temperature,
    input  logic                                s_grid_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gsfb_pkg::VAL_W-1:0]   m_new_value,
    output logic [gsfb_pkg::CELL_W-1:0]         m_cell_row,
    output logic [gsfb_pkg::CELL_W-1:0]         m_cell_col,
    output logic                                m_last_in_step,
    output logic                                m_last_of_grid
);
    import gsfb_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    edge_cfg_t               edge_cfg;
    logic [RW-1:0]           last_row, st_row;
    logic [CW-1:0]           last_col, st_col;
    logic signed [SUM_W-1:0] st_sum;
    logic [NRES_W-1:0]       st_nres, push_cnt;
    logic [NRES_W:0]         pend_front;
    res_t [MAX_RES-1:0]      push_data;
    res_t                    m_data;
    logic [CNT_W-1:0]        fifo_count;
    logic [NEED_W-1:0]       need;
    logic                    accept;

    assign need    = NEED_W'(fifo_count) + NEED_W'(pend_front) + NEED_W'(push_cnt)
                   + NEED_W'(MAX_RES);
    assign s_ready = (need <= NEED_W'(FIFO_DEPTH));
    assign accept  = s_valid && s_ready;

    gsfb_cfg_regs #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .edge_cfg  (edge_cfg),
        .last_row  (last_row),
        .last_col  (last_col)
    );

    gsfb_window #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .temperature (s_temperature),
        .grid_start  (s_grid_start),
        .last_row    (last_row),
        .last_col    (last_col),
        .st_row      (st_row),
        .st_col      (st_col),
        .st_sum      (st_sum),
        .st_nres     (st_nres),
        .pend        (pend_front)
    );

    gsfb_calc #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .edge_cfg  (edge_cfg),
        .last_row  (last_row),
        .last_col  (last_col),
        .st_row    (st_row),
        .st_col    (st_col),
        .st_sum    (st_sum),
        .st_nres   (st_nres),
        .push_cnt  (push_cnt),
        .push_data (push_data)
    );

    gsfb_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .count     (fifo_count),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_new_value    = m_data.new_value;
    assign m_cell_row     = m_data.cell_row;
    assign m_cell_col     = m_data.cell_col;
    assign m_last_in_step = m_data.last_in_step;
    assign m_last_of_grid = m_data.last_of_grid;

endmodule

`default_nettype wire

[rtl/core/gsfb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// gsfb_cfg_regs
// Configuration registers; grid size clamped to last row / last column index.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfb_cfg_regs #(
    parameter int MAX_ROWS = gsfb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gsfb_pkg::MAX_COLS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gsfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsfb_pkg::VAL_W-1:0]       cfg_wdata,
    output gsfb_pkg::edge_cfg_t              edge_cfg,
    output logic [$clog2(MAX_ROWS)-1:0]      last_row,
    output logic [$clog2(MAX_COLS)-1:0]      last_col
);
    import gsfb_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    edge_cfg_t         edge_cfg_reg;
    logic [RW-1:0]     last_row_reg;
    logic [CW-1:0]     last_col_reg;

    function automatic int unsigned last_index(input logic [SIZE_W-1:0] v,
                                               input int unsigned maxv);
        int unsigned x;
        x = 32'(v);
        if (x < 3) return 2;
        if (x > maxv) return maxv - 1;
        return x - 1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_cfg_reg.top_edge   <= TOP_EDGE_RST;
            edge_cfg_reg.bot_edge   <= BOT_EDGE_RST;
            edge_cfg_reg.left_edge  <= LEFT_EDGE_RST;
            edge_cfg_reg.right_edge <= RIGHT_EDGE_RST;
            edge_cfg_reg.gain       <= GAIN_RST;
            last_row_reg            <= RW'(last_index(ROWS_RST, MAX_ROWS));
            last_col_reg            <= CW'(last_index(COLS_RST, MAX_COLS));
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TOP_EDGE:   edge_cfg_reg.top_edge   <= cfg_wdata;
                    CFG_BOT_EDGE:   edge_cfg_reg.bot_edge   <= cfg_wdata;
                    CFG_LEFT_EDGE:  edge_cfg_reg.left_edge  <= cfg_wdata;
                    CFG_RIGHT_EDGE: edge_cfg_reg.right_edge <= cfg_wdata;
                    CFG_GAIN:       edge_cfg_reg.gain       <= cfg_wdata;
                    CFG_ROWS:       last_row_reg <=
                        RW'(last_index(cfg_wdata[SIZE_W-1:0], MAX_ROWS));
                    CFG_COLS:       last_col_reg <=
                        CW'(last_index(cfg_wdata[SIZE_W-1:0], MAX_COLS));
                    default: ;
                endcase
            end
        end
    end

    assign edge_cfg = edge_cfg_reg;
    assign last_row = last_row_reg;
    assign last_col = last_col_reg;

endmodule

`default_nettype wire

[rtl/core/gsfb_window.sv]
// ----------------------------------------------------------------------------
// gsfb_window
// Position counters, two line memories and a two-column window; forms the
// registered nine-cell sum and the result count of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfb_window #(
    parameter int MAX_ROWS = gsfb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gsfb_pkg::MAX_COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic signed [gsfb_pkg::VAL_W-1:0] temperature,
    input  logic                              grid_start,
    input  logic [$clog2(MAX_ROWS)-1:0]       last_row,
    input  logic [$clog2(MAX_COLS)-1:0]       last_col,
    output logic [$clog2(MAX_ROWS)-1:0]       st_row,
    output logic [$clog2(MAX_COLS)-1:0]       st_col,
    output logic signed [gsfb_pkg::SUM_W-1:0] st_sum,
    output logic [gsfb_pkg::NRES_W-1:0]       st_nres,
    output logic [gsfb_pkg::NRES_W:0]         pend
);
    import gsfb_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int CS_W = VAL_W + 2;

    logic [RW-1:0] row_cnt_reg, row_cnt_next, row_base, r_in;
    logic [CW-1:0] col_cnt_reg, col_cnt_next, col_base, c_in;
    logic          last_r_in, last_c_in;
    logic [NRES_W-1:0] nres_in;

    logic [VAL_W-1:0] upper_line_mem  [MAX_COLS];
    logic [VAL_W-1:0] middle_line_mem [MAX_COLS];

    logic                    v1_reg;
    logic [NRES_W-1:0]       nres1_reg;
    logic [RW-1:0]           r1_reg;
    logic [CW-1:0]           c1_reg;
    logic signed [VAL_W-1:0] low1_reg;
    logic signed [VAL_W-1:0] up_rd_reg, mid_rd_reg;
    logic                    fwd_reg;
    logic signed [VAL_W-1:0] fwd_up_reg, fwd_mid_reg;
    logic signed [VAL_W-1:0] up_eff, mid_eff;
    logic signed [CS_W-1:0]  colsum;
    logic signed [CS_W-1:0]  cs_old_reg, cs_new_reg;
    logic signed [SUM_W-1:0] sum_next;

    logic [NRES_W-1:0]       nres2_reg;
    logic [RW-1:0]           r2_reg;
    logic [CW-1:0]           c2_reg;
    logic signed [SUM_W-1:0] sum2_reg;

    always_comb begin
        row_base  = grid_start ? '0 : row_cnt_reg;
        col_base  = grid_start ? '0 : col_cnt_reg;
        r_in      = (row_base > last_row) ? last_row : row_base;
        c_in      = (col_base > last_col) ? last_col : col_base;
        last_r_in = (r_in == last_row);
        last_c_in = (c_in == last_col);
        if (r_in == '0 || c_in == '0) begin
            nres_in = '0;
        end else if (last_r_in && last_c_in) begin
            nres_in = NRES_W'(4);
        end else if (last_r_in || last_c_in) begin
            nres_in = NRES_W'(2);
        end else begin
            nres_in = NRES_W'(1);
        end
        if (last_c_in) begin
            col_cnt_next = '0;
            row_cnt_next = last_r_in ? '0 : r_in + 1'b1;
        end else begin
            col_cnt_next = c_in + 1'b1;
            row_cnt_next = r_in;
        end
    end

    // previous item wrote the same column as this item's memory read: bypass the memory
    assign up_eff  = fwd_reg ? fwd_up_reg  : up_rd_reg;
    assign mid_eff = fwd_reg ? fwd_mid_reg : mid_rd_reg;

    assign colsum   = CS_W'(up_eff) + CS_W'(mid_eff) + CS_W'(low1_reg);
    assign sum_next = SUM_W'(cs_old_reg) + SUM_W'(cs_new_reg) + SUM_W'(colsum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            nres1_reg   <= '0;
            nres2_reg   <= '0;
            fwd_reg     <= 1'b0;
            cs_old_reg  <= '0;
            cs_new_reg  <= '0;
        end else begin
            if (accept) begin
                row_cnt_reg <= row_cnt_next;
                col_cnt_reg <= col_cnt_next;
                fwd_reg     <= v1_reg && (c1_reg == c_in);
            end
            v1_reg    <= accept;
            nres1_reg <= accept ? nres_in : '0;
            nres2_reg <= nres1_reg;
            if (v1_reg) begin
                cs_old_reg <= cs_new_reg;
                cs_new_reg <= colsum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            r1_reg      <= r_in;
            c1_reg      <= c_in;
            low1_reg    <= temperature;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= low1_reg;
        end
        r2_reg   <= r1_reg;
        c2_reg   <= c1_reg;
        sum2_reg <= sum_next;
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            upper_line_mem[c1_reg]  <= mid_eff;
            middle_line_mem[c1_reg] <= low1_reg;
        end
        if (accept) begin
            up_rd_reg  <= upper_line_mem[c_in];
            mid_rd_reg <= middle_line_mem[c_in];
        end
    end

    assign st_row  = r2_reg;
    assign st_col  = c2_reg;
    assign st_sum  = sum2_reg;
    assign st_nres = nres2_reg;
    assign pend    = {1'b0, nres1_reg} + {1'b0, nres2_reg};

endmodule

`default_nettype wire

[rtl/core/gsfb_calc.sv]
// ----------------------------------------------------------------------------
// gsfb_calc
// Gain multiply, round and saturate, border values; builds the up to four
// results of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfb_calc #(
    parameter int MAX_ROWS = gsfb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gsfb_pkg::MAX_COLS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  gsfb_pkg::edge_cfg_t                      edge_cfg,
    input  logic [$clog2(MAX_ROWS)-1:0]              last_row,
    input  logic [$clog2(MAX_COLS)-1:0]              last_col,
    input  logic [$clog2(MAX_ROWS)-1:0]              st_row,
    input  logic [$clog2(MAX_COLS)-1:0]              st_col,
    input  logic signed [gsfb_pkg::SUM_W-1:0]        st_sum,
    input  logic [gsfb_pkg::NRES_W-1:0]              st_nres,
    output logic [gsfb_pkg::NRES_W-1:0]              push_cnt,
    output gsfb_pkg::res_t [gsfb_pkg::MAX_RES-1:0]   push_data
);
    import gsfb_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int Q_W = PROD_W + 1 - 16;

    logic [NRES_W-1:0]        nres3_reg;
    logic [RW-1:0]            r3_reg;
    logic [CW-1:0]            c3_reg;
    logic signed [PROD_W-1:0] prod3_reg;
    logic signed [16:0]       gain_s;

    logic signed [PROD_W:0]   rnd;
    logic signed [Q_W-1:0]    q;
    logic signed [VAL_W-1:0]  sat;
    logic [RW-1:0]            orow;
    logic [CW-1:0]            ocol;
    logic                     last_r, last_c, interior;

    function automatic logic signed [VAL_W-1:0] floor_mean(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        return s[VAL_W:1];
    endfunction

    function automatic logic signed [VAL_W-1:0] border_val(
        input logic fr, input logic lr, input logic fc, input logic lc,
        input edge_cfg_t e
    );
        logic signed [VAL_W-1:0] v;
        if (fr && fc)      v = floor_mean(e.left_edge, e.top_edge);
        else if (fr && lc) v = floor_mean(e.top_edge, e.right_edge);
        else if (lr && fc) v = floor_mean(e.left_edge, e.bot_edge);
        else if (lr && lc) v = floor_mean(e.right_edge, e.bot_edge);
        else if (fr)       v = e.top_edge;
        else if (lr)       v = e.bot_edge;
        else if (fc)       v = e.left_edge;
        else               v = e.right_edge;
        return v;
    endfunction

    assign gain_s = {1'b0, edge_cfg.gain};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nres3_reg <= '0;
        end else begin
            nres3_reg <= st_nres;
        end
    end

    always_ff @(posedge aclk) begin
        r3_reg    <= st_row;
        c3_reg    <= st_col;
        prod3_reg <= st_sum * gain_s;
    end

    always_comb begin
        // round half up, then floor shift
        rnd = {prod3_reg[PROD_W-1], prod3_reg} + (PROD_W+1)'(32768);
        q   = rnd[PROD_W:16];
        if (q > Q_W'(32767)) begin
            sat = 16'sh7fff;
        end else if (q < -Q_W'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = q[VAL_W-1:0];
        end

        orow     = r3_reg - 1'b1;
        ocol     = c3_reg - 1'b1;
        last_r   = (r3_reg == last_row);
        last_c   = (c3_reg == last_col);
        interior = (orow != '0) && (orow != last_row) && (ocol != '0) && (ocol != last_col);

        // cell one row up and one column left
        push_data[0].new_value    = interior ? sat :
            border_val(orow == '0, orow == last_row, ocol == '0, ocol == last_col, edge_cfg);
        push_data[0].cell_row     = CELL_W'(orow);
        push_data[0].cell_col     = CELL_W'(ocol);
        push_data[0].last_of_grid = (orow == last_row) && (ocol == last_col);

        // bottom row cell on the last row, else right column cell
        if (last_r) begin
            push_data[1].new_value    = border_val(r3_reg == '0, 1'b1, ocol == '0,
                                                   ocol == last_col, edge_cfg);
            push_data[1].cell_row     = CELL_W'(r3_reg);
            push_data[1].cell_col     = CELL_W'(ocol);
            push_data[1].last_of_grid = (ocol == last_col);
        end else begin
            push_data[1].new_value    = border_val(orow == '0, orow == last_row,
                                                   c3_reg == '0, 1'b1, edge_cfg);
            push_data[1].cell_row     = CELL_W'(orow);
            push_data[1].cell_col     = CELL_W'(c3_reg);
            push_data[1].last_of_grid = (orow == last_row) && last_c;
        end

        push_data[2].new_value    = border_val(orow == '0, orow == last_row,
                                               c3_reg == '0, last_c, edge_cfg);
        push_data[2].cell_row     = CELL_W'(orow);
        push_data[2].cell_col     = CELL_W'(c3_reg);
        push_data[2].last_of_grid = (orow == last_row) && last_c;

        push_data[3].new_value    = border_val(r3_reg == '0, last_r, c3_reg == '0, last_c,
                                               edge_cfg);
        push_data[3].cell_row     = CELL_W'(r3_reg);
        push_data[3].cell_col     = CELL_W'(c3_reg);
        push_data[3].last_of_grid = last_r && last_c;

        for (int i = 0; i < MAX_RES; i++) begin
            push_data[i].last_in_step = (NRES_W'(i) == nres3_reg - 1'b1);
        end
    end

    assign push_cnt = nres3_reg;

endmodule

`default_nettype wire

[rtl/core/gsfb_result_fifo.sv]
// ----------------------------------------------------------------------------
// gsfb_result_fifo
// Result queue: up to four items written per cycle, one item read per cycle while m_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfb_result_fifo (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [gsfb_pkg::NRES_W-1:0]            push_cnt,
    input  gsfb_pkg::res_t [gsfb_pkg::MAX_RES-1:0] push_data,
    output logic [gsfb_pkg::CNT_W-1:0]             count,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output gsfb_pkg::res_t                         m_data
);
    import gsfb_pkg::*;

    res_t              queue_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign m_valid    = (count_reg != '0);
    assign pop        = m_valid && m_ready;
    assign count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (NRES_W'(i) < push_cnt) begin
                queue_reg[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
            end
        end
    end

    assign m_data = queue_reg[rd_ptr_reg];
    assign count  = count_reg;

endmodule

`default_nettype wire

[rtl/core/gsfb_checker.sv]
// ----------------------------------------------------------------------------
// gsfb_checker
// Port-level checks of the stencil step, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_stencil_step_fixed_border_macros.svh"

module gsfb_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_ready,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [gsfb_pkg::VAL_W-1:0]   m_new_value,
    input  logic [gsfb_pkg::CELL_W-1:0]         m_cell_row,
    input  logic [gsfb_pkg::CELL_W-1:0]         m_cell_col,
    input  logic                                m_last_in_step,
    input  logic                                m_last_of_grid
);

    `GSFB_ASSERT_RST(a_out_hold,
        m_valid && !m_ready |=> m_valid && $stable(m_new_value)
            && $stable(m_cell_row) && $stable(m_cell_col),
        "result item changed while stalled")

    // all results of one item enter the queue together
    `GSFB_ASSERT_RST(a_step_contiguous,
        m_valid && m_ready && !m_last_in_step |=> m_valid,
        "gap inside the results of one item")

    `GSFB_ASSERT_RST(a_corner_last,
        m_valid && m_last_of_grid |-> m_last_in_step,
        "bottom-right corner is not the last result of its item")

    `GSFB_ASSERT(a_reset_empty,
        !aresetn |=> !m_valid && s_ready,
        "block not empty and ready after reset")

endmodule

bind grid_stencil_step_fixed_border gsfb_checker u_gsfb_checker (.*);

`default_nettype wire
